### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the RMC time extractor.
// No dependencies; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/nrte_pkg.sv
// Package for the RMC time extractor: character codes, the event record
// passed from the parser to the output stage, and small decode helpers.
package nrte_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [2:0] PREFIX_LEN = 3'd6;
    localparam logic [2:0] TIME_DIGITS_MAX = 3'd6;
    localparam logic [1:0] HEX_KEEP = 2'd2;
    localparam logic [1:0] HEX_SAT = 2'd3;
    localparam logic [1:0] FIELD_SAT = 2'd3;
    localparam logic [1:0] FIELD_STATUS = 2'd2;
    localparam logic [1:0] FIELD_TIME = 2'd1;
    localparam logic [1:0] FIELD_PREFIX = 2'd0;

    localparam logic [4:0] ZONE_RESET = 5'd8;
    localparam logic [4:0] ZONE_WRAP = 5'd24;
    localparam logic [7:0] HOURS_WRAP = 8'd24;

    // Parser to output stage: one record per token end or stop character
    typedef struct packed {
        logic       ok;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
    } t_event;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0: ch = CH_DOLLAR;
            3'd1: ch = 8'h47;   // G
            3'd2: ch = 8'h50;   // P
            3'd3: ch = 8'h52;   // R
            3'd4: ch = 8'h4D;   // M
            3'd5: ch = 8'h43;   // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    // Two BCD digits to binary, 0..99
    function automatic logic [6:0] bcd_pair(input logic [3:0] hi, input logic [3:0] lo);
        return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
    endfunction

endpackage

### rtl/nrte_front.sv
// Character parser: tokenizes the stream, checks prefix, status and checksum,
// and collects the time digits. Uses nrte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nrte_front import nrte_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_event     o_event
);

    logic        r_stopped,       n_stopped;
    logic        r_token_started, n_token_started;
    logic [1:0]  r_field_count,   n_field_count;
    logic [2:0]  r_prefix_pos,    n_prefix_pos;
    logic        r_prefix_match,  n_prefix_match;
    logic [7:0]  r_xor_acc,       n_xor_acc;
    logic        r_seen_star,     n_seen_star;
    logic [7:0]  r_hex_acc,       n_hex_acc;
    logic [1:0]  r_hex_count,     n_hex_count;
    logic [23:0] r_time_bcd,      n_time_bcd;
    logic [2:0]  r_time_digits,   n_time_digits;
    logic        r_status_active, n_status_active;
    logic        r_field_open,    n_field_open;
    logic        r_any_field,     n_any_field;
    logic        r_dollar_first,  n_dollar_first;
    logic        r_hex_done,      n_hex_done;
    logic        r_time_done,     n_time_done;

    logic       w_space;
    logic       w_finish_ok;
    logic [4:0] w_hex;
    logic [1:0] w_fc_eff;
    logic       w_field_first;

    assign w_space = (i_char == CH_SPACE) || (i_char inside {[8'h09:8'h0D]});
    assign w_hex   = hex_decode(i_char);
    assign o_ready = !i_full;

    assign w_finish_ok = r_prefix_match && (r_prefix_pos == PREFIX_LEN)
                      && (r_field_count >= FIELD_STATUS) && r_status_active
                      && r_dollar_first && r_seen_star
                      && (r_hex_count != 2'd0) && (r_hex_count <= HEX_KEEP)
                      && (r_hex_acc == r_xor_acc);

    assign o_event.ok      = w_finish_ok && w_space;
    assign o_event.hours   = bcd_pair(r_time_bcd[23:20], r_time_bcd[19:16]);
    assign o_event.minutes = bcd_pair(r_time_bcd[15:12], r_time_bcd[11:8]);
    assign o_event.seconds = bcd_pair(r_time_bcd[7:4],   r_time_bcd[3:0]);

    always_comb begin
        n_stopped       = r_stopped;
        n_token_started = r_token_started;
        n_field_count   = r_field_count;
        n_prefix_pos    = r_prefix_pos;
        n_prefix_match  = r_prefix_match;
        n_xor_acc       = r_xor_acc;
        n_seen_star     = r_seen_star;
        n_hex_acc       = r_hex_acc;
        n_hex_count     = r_hex_count;
        n_time_bcd      = r_time_bcd;
        n_time_digits   = r_time_digits;
        n_status_active = r_status_active;
        n_field_open    = r_field_open;
        n_any_field     = r_any_field;
        n_dollar_first  = r_dollar_first;
        n_hex_done      = r_hex_done;
        n_time_done     = r_time_done;
        o_push          = 1'b0;
        w_fc_eff        = r_field_count;
        w_field_first   = 1'b0;

        if (i_valid && o_ready && !r_stopped) begin
            if (w_space) begin
                if (r_token_started) begin
                    // token end: report and clear the token state
                    o_push          = 1'b1;
                    n_token_started = 1'b0;
                    n_field_count   = FIELD_PREFIX;
                    n_prefix_pos    = 3'd0;
                    n_prefix_match  = 1'b1;
                    n_xor_acc       = 8'd0;
                    n_seen_star     = 1'b0;
                    n_hex_acc       = 8'd0;
                    n_hex_count     = 2'd0;
                    n_time_bcd      = 24'd0;
                    n_time_digits   = 3'd0;
                    n_status_active = 1'b0;
                    n_field_open    = 1'b0;
                    n_any_field     = 1'b0;
                    n_dollar_first  = 1'b0;
                    n_hex_done      = 1'b0;
                    n_time_done     = 1'b0;
                end
            end else if (!r_token_started && i_char == CH_E) begin
                n_stopped = 1'b1;
                o_push    = 1'b1;
            end else begin
                n_token_started = 1'b1;
                if (!r_token_started) begin
                    n_dollar_first = (i_char == CH_DOLLAR);
                end

                // checksum over the body, then hex digits after the star
                if (r_token_started && r_dollar_first) begin
                    if (!r_seen_star) begin
                        if (i_char == CH_STAR) begin
                            n_seen_star = 1'b1;
                        end else begin
                            n_xor_acc = r_xor_acc ^ i_char;
                        end
                    end else if (!r_hex_done) begin
                        if (!w_hex[4]) begin
                            n_hex_done = 1'b1;
                        end else begin
                            if (r_hex_count < HEX_KEEP) begin
                                n_hex_acc = {r_hex_acc[3:0], w_hex[3:0]};
                            end
                            if (r_hex_count < HEX_SAT) begin
                                n_hex_count = r_hex_count + 2'd1;
                            end
                        end
                    end
                end

                // comma fields; runs of commas collapse
                if (i_char == CH_COMMA) begin
                    n_field_open = 1'b0;
                end else begin
                    if (!r_field_open) begin
                        w_field_first = 1'b1;
                        if (r_any_field && r_field_count != FIELD_SAT) begin
                            w_fc_eff = r_field_count + 2'd1;
                        end
                    end
                    n_field_count = w_fc_eff;
                    n_any_field   = 1'b1;
                    n_field_open  = 1'b1;

                    case (w_fc_eff)
                        FIELD_PREFIX: begin
                            if (r_prefix_pos < PREFIX_LEN) begin
                                if (i_char != prefix_char(r_prefix_pos)) begin
                                    n_prefix_match = 1'b0;
                                end
                                n_prefix_pos = r_prefix_pos + 3'd1;
                            end else begin
                                n_prefix_match = 1'b0;
                            end
                        end
                        FIELD_TIME: begin
                            if (!r_time_done) begin
                                if (i_char inside {[8'h30:8'h39]}
                                        && r_time_digits < TIME_DIGITS_MAX) begin
                                    n_time_bcd    = {r_time_bcd[19:0], i_char[3:0]};
                                    n_time_digits = r_time_digits + 3'd1;
                                end else begin
                                    n_time_done = 1'b1;
                                end
                            end
                        end
                        FIELD_STATUS: begin
                            if (w_field_first) begin
                                n_status_active = (i_char == CH_A);
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped       <= 1'b0;
            r_token_started <= 1'b0;
            r_field_count   <= FIELD_PREFIX;
            r_prefix_pos    <= 3'd0;
            r_prefix_match  <= 1'b1;
            r_xor_acc       <= 8'd0;
            r_seen_star     <= 1'b0;
            r_hex_acc       <= 8'd0;
            r_hex_count     <= 2'd0;
            r_time_bcd      <= 24'd0;
            r_time_digits   <= 3'd0;
            r_status_active <= 1'b0;
            r_field_open    <= 1'b0;
            r_any_field     <= 1'b0;
            r_dollar_first  <= 1'b0;
            r_hex_done      <= 1'b0;
            r_time_done     <= 1'b0;
        end else begin
            r_stopped       <= n_stopped;
            r_token_started <= n_token_started;
            r_field_count   <= n_field_count;
            r_prefix_pos    <= n_prefix_pos;
            r_prefix_match  <= n_prefix_match;
            r_xor_acc       <= n_xor_acc;
            r_seen_star     <= n_seen_star;
            r_hex_acc       <= n_hex_acc;
            r_hex_count     <= n_hex_count;
            r_time_bcd      <= n_time_bcd;
            r_time_digits   <= n_time_digits;
            r_status_active <= n_status_active;
            r_field_open    <= n_field_open;
            r_any_field     <= n_any_field;
            r_dollar_first  <= n_dollar_first;
            r_hex_done      <= n_hex_done;
            r_time_done     <= n_time_done;
        end
    end

    `ASSERT_SYNC(a_stop_sticks, i_clk, i_rst_n, r_stopped |=> r_stopped, "stop flag cleared")
    `ASSERT_NEVER(a_prefix_pos, i_clk, i_rst_n, r_prefix_pos > PREFIX_LEN, "prefix overrun")
    `ASSERT_SYNC(a_push_space, i_clk, i_rst_n, (o_push && !r_stopped && !n_stopped) |-> (w_space && r_token_started), "push without token end")

endmodule

### rtl/nrte_fifo.sv
// Two-entry event queue between the parser and the output stage.
// Uses nrte_pkg for the event record and assert_macros.svh.
`include "assert_macros.svh"

module nrte_fifo import nrte_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_event o_data,
    output logic   o_empty
);

    t_event     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `ASSERT_SYNC(a_ptr_count, i_clk, i_rst_n, (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr), "pointers disagree with count")

endmodule

### rtl/nrte_back.sv
// Output stage: applies the zone offset, keeps the stored time and holds
// the result register. Uses nrte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nrte_back import nrte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [4:0]  i_cfg_data,
    input  t_event      i_event,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_updated,
    output logic [6:0]  o_hours,
    output logic [6:0]  o_minutes,
    output logic [6:0]  o_seconds,
    output logic        o_has_time
);

    logic [4:0] r_zone;
    logic [6:0] r_last_hours, r_last_minutes, r_last_seconds;
    logic       r_out_valid;
    logic       r_out_updated, r_out_has_time;
    logic [6:0] r_out_hours, r_out_minutes, r_out_seconds;

    logic [4:0] w_zone_mod;
    logic [7:0] w_hour_sum;
    logic [7:0] w_hour_adj;
    logic [6:0] n_hours, n_minutes, n_seconds;

    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    assign w_zone_mod = (r_zone >= ZONE_WRAP) ? (r_zone - ZONE_WRAP) : r_zone;
    assign w_hour_sum = {1'b0, i_event.hours} + {3'b000, w_zone_mod};
    assign w_hour_adj = (w_hour_sum >= HOURS_WRAP) ? (w_hour_sum - HOURS_WRAP) : w_hour_sum;

    always_comb begin
        if (i_event.ok) begin
            n_hours   = w_hour_adj[6:0];
            n_minutes = i_event.minutes;
            n_seconds = i_event.seconds;
        end else begin
            n_hours   = r_last_hours;
            n_minutes = r_last_minutes;
            n_seconds = r_last_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone         <= ZONE_RESET;
            r_last_hours   <= 7'd0;
            r_last_minutes <= 7'd0;
            r_last_seconds <= 7'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_zone <= i_cfg_data;
            end
            if (o_pop) begin
                r_last_hours   <= n_hours;
                r_last_minutes <= n_minutes;
                r_last_seconds <= n_seconds;
                r_out_valid    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_updated  <= i_event.ok;
            r_out_hours    <= n_hours;
            r_out_minutes  <= n_minutes;
            r_out_seconds  <= n_seconds;
            r_out_has_time <= |{n_hours, n_minutes, n_seconds};
        end
    end

    assign o_valid    = r_out_valid;
    assign o_updated  = r_out_updated;
    assign o_hours    = r_out_hours;
    assign o_minutes  = r_out_minutes;
    assign o_seconds  = r_out_seconds;
    assign o_has_time = r_out_has_time;

    `ASSERT_NEVER(a_hours_range, i_clk, i_rst_n, r_last_hours > 7'd98, "stored hours out of range")
    `ASSERT_SYNC(a_out_matches, i_clk, i_rst_n, r_out_valid |-> (r_out_hours == r_last_hours && r_out_seconds == r_last_seconds), "result differs from stored time")
    `ASSERT_SYNC(a_keep_time, i_clk, i_rst_n, (o_pop && !i_event.ok) |=> (r_last_minutes == $past(r_last_minutes)), "rejected sentence changed time")

endmodule

### rtl/nmea_rmc_time_extractor.sv
// Top level of the RMC time extractor: parser, event queue, output stage.
// Uses nrte_pkg, nrte_front, nrte_fifo and nrte_back.
//
//   channel     direction  payload (lowest bit first)
//   s_axis      in         tdata: char_in[7:0]
//   m_axis      out        tdata: hours, minutes, seconds, has_time; tuser: updated
//   cfg         in         data: zone_offset_hours[4:0]
//
// One character is taken per cycle. A token end or stop character enters the
// queue at its transfer edge, then moves to the output register when free.
// The input stalls while the two-entry queue is full, which happens only after
// the output has been held; the output stalls only on its own ready.
// Reset is synchronous, active low, and clears all control state; the zone
// offset resets to eight hours. The config port is always ready.

module nmea_rmc_time_extractor import nrte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_in
    // time results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [6:0] hours, [13:7] minutes,
                                          // [20:14] seconds, [21] has_time
    output logic        o_m_axis_tuser,   // [0] updated
    // zone offset register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    t_event     w_push_event;
    t_event     w_pop_event;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    logic [6:0] w_hours, w_minutes, w_seconds;
    logic       w_has_time;

    // parse characters and emit one event per token end or stop
    nrte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_char  (i_s_axis_tdata),
        .o_ready (o_s_axis_tready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_event (w_push_event)
    );

    // decouple parser from a stalled output
    nrte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_event),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_event),
        .o_empty (w_empty)
    );

    // apply zone offset, update stored time, drive the result register
    nrte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_event    (w_pop_event),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_updated  (o_m_axis_tuser),
        .o_hours    (w_hours),
        .o_minutes  (w_minutes),
        .o_seconds  (w_seconds),
        .o_has_time (w_has_time)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {2'b00, w_has_time, w_seconds, w_minutes, w_hours};

endmodule

### test/tb_nmea_rmc_time_extractor.sv
// Self-checking testbench for nmea_rmc_time_extractor: RMC sentences, broken and noisy
// tokens, zone offsets and back-pressure against a built-in sentence predictor.
// Depends on nrte_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_nmea_rmc_time_extractor;
    import nrte_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;

    // Checksum trailer shapes used to build sentences
    typedef enum int {
        SUM_UPPER, SUM_LOWER, SUM_ONE, SUM_THREE, SUM_NONE, SUM_EMPTY, SUM_BAD, SUM_TRAIL
    } t_sum_style;

    // One time report as the output stage presents it
    typedef struct packed {
        logic       updated;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic       has_time;
    } t_time_report;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [4:0]  cfg_data = 5'd0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_cfg_ready;

    nmea_rmc_time_extractor dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sentence predictor: mirrors the parser state character by character
    // ------------------------------------------------------------------
    t_time_report reports_due[$];
    string        rmc_tag = "$GPRMC";

    bit       halted;             // set by a token that opens with the stop character
    bit       tok_open;
    bit       lead_dollar;
    int       fld_idx;            // saturates at 3
    bit       fld_open, any_fld;
    int       tag_pos;
    bit       tag_ok;
    bit [7:0] run_xor;
    bit       star_seen, sum_closed;
    bit [7:0] sum_field;
    int       sum_digits;         // saturates at 3
    int       hhmmss_acc, hhmmss_digits;
    bit       hhmmss_closed;
    bit       status_ok;
    int       stored_hhmmss;
    bit [4:0] zone_hours;

    function automatic void clear_sentence();
        tok_open      = 1'b0;
        lead_dollar   = 1'b0;
        fld_idx       = 0;
        fld_open      = 1'b0;
        any_fld       = 1'b0;
        tag_pos       = 0;
        tag_ok        = 1'b1;
        run_xor       = 8'h00;
        star_seen     = 1'b0;
        sum_closed    = 1'b0;
        sum_field     = 8'h00;
        sum_digits    = 0;
        hhmmss_acc    = 0;
        hhmmss_digits = 0;
        hhmmss_closed = 1'b0;
        status_ok     = 1'b0;
    endfunction

    function automatic void reset_parser();
        halted        = 1'b0;
        stored_hhmmss = 0;
        zone_hours    = ZONE_RESET;
        clear_sentence();
    endfunction

    function automatic int hex_nibble(bit [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void post_report(bit upd);
        t_time_report r;
        r.updated  = upd;
        r.hours    = 7'(stored_hhmmss / 10000);
        r.minutes  = 7'((stored_hhmmss % 10000) / 100);
        r.seconds  = 7'(stored_hhmmss % 100);
        r.has_time = (stored_hhmmss != 0);
        reports_due.push_back(r);
    endfunction

    // Close the sentence: all of tag, field count, status and checksum must hold
    function automatic void close_sentence();
        bit tag_good, sum_good, accept;
        int t;
        tag_good = tag_ok && tag_pos == 6;
        sum_good = lead_dollar && star_seen && sum_digits >= 1 && sum_digits <= 2 &&
                   sum_field == run_xor;
        accept   = tag_good && fld_idx >= 2 && status_ok && sum_good;
        if (accept) begin
            t = hhmmss_acc + (zone_hours % 24) * 10000;
            if (t >= 240000) t -= 240000;
            stored_hhmmss = t & 20'hFFFFF;
        end
        post_report(accept);
        clear_sentence();
    endfunction

    function automatic void parse_rmc_char(bit [7:0] c);
        bit is_ws, opening, fld_start;
        int nib;
        is_ws = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
        if (halted) return;
        if (is_ws) begin
            if (tok_open) close_sentence();
            return;
        end
        if (!tok_open && c == CH_E) begin
            halted = 1'b1;
            post_report(1'b0);
            return;
        end
        opening  = !tok_open;
        tok_open = 1'b1;
        if (opening) lead_dollar = (c == CH_DOLLAR);

        // XOR up to the star, then collect hex digits until a non-hex character
        if (!opening && lead_dollar) begin
            if (!star_seen) begin
                if (c == CH_STAR) star_seen = 1'b1;
                else run_xor ^= c;
            end else if (!sum_closed) begin
                nib = hex_nibble(c);
                if (nib < 0) begin
                    sum_closed = 1'b1;
                end else begin
                    if (sum_digits < 2) sum_field = {sum_field[3:0], nib[3:0]};
                    if (sum_digits < 3) sum_digits++;
                end
            end
        end

        // Comma runs collapse: a field opens only on its first non-comma
        if (c == CH_COMMA) begin
            fld_open = 1'b0;
            return;
        end
        fld_start = 1'b0;
        if (!fld_open) begin
            if (any_fld && fld_idx < 3) fld_idx++;
            any_fld   = 1'b1;
            fld_open  = 1'b1;
            fld_start = 1'b1;
        end
        case (fld_idx)
            0: begin
                if (tag_pos < 6) begin
                    if (c != rmc_tag[tag_pos]) tag_ok = 1'b0;
                    tag_pos++;
                end else begin
                    tag_ok = 1'b0;
                end
            end
            1: begin
                if (!hhmmss_closed) begin
                    if (c >= "0" && c <= "9" && hhmmss_digits < 6) begin
                        hhmmss_acc = hhmmss_acc * 10 + (c - "0");
                        hhmmss_digits++;
                    end else begin
                        hhmmss_closed = 1'b1;
                    end
                end
            end
            2: if (fld_start) status_ok = (c == CH_A);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    int chars_sent   = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit shield_stop  = 1'b1;   // keep the stop character off token starts until the last test
    int hold_req     = 0;
    int errors       = 0;

    // Offer one character and hold it until the transfer; valid stays high afterwards
    // so back-to-back characters never drop it within one time step.
    task automatic send_char(input bit [7:0] c);
        if (shield_stop && !tok_open && !halted && c == CH_E) c = 8'h46;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        parse_rmc_char(c);
        chars_sent++;
    endtask

    // End a token with one of the whitespace codes, sometimes a CR LF style pair
    task automatic send_ws();
        int n;
        n = $urandom_range(0, 6);
        send_char(n > 4 ? CH_SPACE : 8'(9 + n));
        if ($urandom_range(0, 6) == 0) send_char(8'd10);
    endtask

    task automatic send_token(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_ws();
    endtask

    // Drop valid, wait for every pending report, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_zone(input bit [4:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid  <= 1'b0;
        zone_hours = v;
    endtask

    // ------------------------------------------------------------------
    // Sentence text builders
    // ------------------------------------------------------------------
    function automatic bit [7:0] xor_of(string s);
        bit [7:0] x;
        x = 8'h00;
        for (int i = 0; i < s.len(); i++) x ^= s[i];
        return x;
    endfunction

    function automatic string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    // Append the checksum trailer; the leading dollar is left to the caller
    function automatic string with_sum(string body, t_sum_style style);
        bit [7:0] x, pad;
        if (style == SUM_ONE) begin
            // pad one field so the XOR drops below 16 and prints as one digit
            pad  = ((xor_of(body) ^ CH_COMMA) & 8'hF0) | 8'h01;
            body = {body, ",", $sformatf("%c", pad)};
        end
        x = xor_of(body);
        case (style)
            SUM_UPPER: return {body, "*", $sformatf("%02X", x)};
            SUM_LOWER: return {body, "*", $sformatf("%02x", x)};
            SUM_ONE:   return {body, "*", $sformatf("%0X", x)};
            SUM_THREE: return {body, "*", $sformatf("%02X", x), "0"};
            SUM_NONE:  return body;
            SUM_EMPTY: return {body, "*"};
            SUM_BAD:   return {body, "*", $sformatf("%02X", x ^ $urandom_range(1, 255))};
            default:   return {body, "*", $sformatf("%02X", x), "g", digits(2)};
        endcase
    endfunction

    function automatic t_sum_style pick_style();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return SUM_UPPER;
        if (p < 70) return SUM_LOWER;
        if (p < 80) return SUM_ONE;
        if (p < 85) return SUM_THREE;
        if (p < 89) return SUM_NONE;
        if (p < 92) return SUM_EMPTY;
        if (p < 97) return SUM_BAD;
        return SUM_TRAIL;
    endfunction

    function automatic string field_sep();
        return ($urandom_range(0, 7) == 0) ? ",," : ",";
    endfunction

    function automatic string junk_text();
        string s;
        bit [7:0] c;
        int n;
        s = "";
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            if (c == CH_STAR) c = 8'h2E;
            s = {s, $sformatf("%c", c)};
        end
        return s;
    endfunction

    function automatic string hhmmss_text();
        string s;
        case ($urandom_range(0, 9))
            0: s = digits($urandom_range(0, 8));
            1: s = {$sformatf("%c", 8'h41 + $urandom_range(0, 25)), digits(4)};
            default: begin
                s = $sformatf("%02d%02d%02d", $urandom_range(0, 23), $urandom_range(0, 59),
                              $urandom_range(0, 59));
                if ($urandom_range(0, 1) == 1) s = {s, ".", digits($urandom_range(1, 3))};
            end
        endcase
        return s;
    endfunction

    function automatic string rmc_body();
        string b;
        int n;
        case ($urandom_range(0, 19))
            0: b = "GPGGA";
            1: b = "GPRMCX";
            2: b = "GPRM";
            3: b = "gprmc";
            4: b = ",GPRMC";
            default: b = "GPRMC";
        endcase
        b = {b, field_sep(), hhmmss_text()};
        if ($urandom_range(0, 19) == 0) return b;
        case ($urandom_range(0, 9))
            0: b = {b, field_sep(), "V"};
            1: b = {b, field_sep(), "AV"};
            2: b = {b, field_sep(), "a"};
            default: b = {b, field_sep(), "A"};
        endcase
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) b = {b, field_sep(), junk_text()};
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Sink side: random stalls, long holds on request, and the result check
    // ------------------------------------------------------------------
    int hold_left = 0;
    int snk_idle_left = 0;

    always @(posedge i_clk) begin
        t_time_report got, want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got.updated  = o_m_axis_tuser;
                got.hours    = o_m_axis_tdata[6:0];
                got.minutes  = o_m_axis_tdata[13:7];
                got.seconds  = o_m_axis_tdata[20:14];
                got.has_time = o_m_axis_tdata[21];
                if (reports_due.size() == 0) begin
                    errors++;
                    $display({"%0t: report mismatch: expected no report, ",
                              "got upd=%0d %0d:%0d:%0d has_time=%0d"},
                             $realtime, got.updated, got.hours, got.minutes, got.seconds,
                             got.has_time);
                end else begin
                    want = reports_due.pop_front();
                    if (got.updated !== want.updated || got.hours !== want.hours ||
                        got.minutes !== want.minutes || got.seconds !== want.seconds ||
                        got.has_time !== want.has_time) begin
                        errors++;
                        $display({"%0t: report mismatch: expected upd=%0d %0d:%0d:%0d ",
                                  "has_time=%0d, got upd=%0d %0d:%0d:%0d has_time=%0d"},
                                 $realtime, want.updated, want.hours, want.minutes,
                                 want.seconds, want.has_time, got.updated, got.hours,
                                 got.minutes, got.seconds, got.has_time);
                    end
                end
            end

            // Pick up a requested long hold, otherwise stall in short random bursts
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (snk_idle_left != 0) begin
                snk_idle_left--;
                m_tready <= 1'b0;
            end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                snk_idle_left = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** nmea_rmc_time_extractor: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Whitespace with no open token must produce nothing
    task automatic test_whitespace_only();
        for (int i = 9; i <= 13; i++) send_char(8'(i));
        send_char(CH_SPACE);
    endtask

    // Sentences under the reset zone offset of eight hours, all but the last accepted
    task automatic test_valid_sentences();
        send_token({"$", with_sum({"GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,",
                                   "230394,003.1,W"}, SUM_UPPER)});
        send_token({"$", with_sum("GPRMC,203000.00,A,,,x", SUM_LOWER)});   // wraps past 24h
        send_token({"$", with_sum("GPRMC,x12,A", SUM_UPPER)});             // no leading digit
        send_token({"$", with_sum("GPRMC,1234567,A", SUM_UPPER)});         // seven digits
        send_token({"$", with_sum("GPRMC,,,095959,,,A,,1", SUM_UPPER)});   // comma runs
        send_token({"$", with_sum(",GPRMC,010203,A", SUM_UPPER)});         // leading comma
    endtask

    // Every checksum trailer shape but the lower-case one, plus a token without the leading dollar
    task automatic test_checksum_cases();
        send_token({"$", with_sum("GPRMC,111111,A", SUM_ONE)});
        send_token({"$", with_sum("GPRMC,111112,A", SUM_THREE)});
        send_token({"$", with_sum("GPRMC,111113,A", SUM_NONE)});
        send_token({"$", with_sum("GPRMC,111114,A", SUM_EMPTY)});
        send_token({"$", with_sum("GPRMC,111115,A", SUM_BAD)});
        send_token({"$", with_sum("GPRMC,111116,A", SUM_TRAIL)});
        send_token({"!", with_sum("GPRMC,111117,A", SUM_UPPER)});
    endtask

    // Field count, status and tag rejections
    task automatic test_field_cases();
        send_token({"$", with_sum("GPRMC,121212", SUM_UPPER)});
        send_token({"$", with_sum("GPRMC,121213,V", SUM_UPPER)});
        send_token({"$", with_sum("GPRMCC,121214,A", SUM_UPPER)});
        send_token({"$", with_sum("GPGGA,121215,A", SUM_UPPER)});
    endtask

    // Zone offset extremes, a stored zero time and the offset taken modulo 24
    task automatic test_zone_extremes();
        wait_drained();
        write_zone(5'd0);
        send_token({"$", with_sum("GPRMC,000000,A", SUM_UPPER)});
        send_token({"$", with_sum("GPRMC,235959,A", SUM_UPPER)});
        wait_drained();
        write_zone(5'd23);
        send_token({"$", with_sum("GPRMC,235959,A", SUM_UPPER)});
        wait_drained();
        write_zone(5'd31);
        send_token({"$", with_sum("GPRMC,170000,A", SUM_UPPER)});          // wraps to 00:00
        wait_drained();
        write_zone(5'd24);
        send_token({"$", with_sum("GPRMC,000001,A", SUM_UPPER)});
    endtask

    // Mostly well-formed sentences with random content, some broken ones and noise,
    // in phases with different zone offsets and idle rates
    task automatic test_random_traffic();
        int stop_at, pick, cut, bad;
        bit [7:0] rnd;
        string s;
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin write_zone(5'd0);  src_idle_pct = 12; snk_idle_pct = 12; end
                1: begin write_zone(5'd23); src_idle_pct = 0;  snk_idle_pct = 0;  end
                2: begin write_zone(5'd31); src_idle_pct = 30; snk_idle_pct = 30; end
                default: begin
                    write_zone(5'($urandom_range(0, 31)));
                    src_idle_pct = 10;
                    snk_idle_pct = 0;
                end
            endcase
            stop_at = chars_sent + 180;
            while (chars_sent < stop_at) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_token({"$", with_sum(rmc_body(), pick_style())});
                end else if (pick < 85) begin
                    // truncated sentence, sometimes with one character replaced
                    s   = {"$", with_sum(rmc_body(), SUM_UPPER)};
                    cut = $urandom_range(1, s.len());
                    bad = $urandom_range(0, 2 * cut);
                    for (int i = 0; i < cut; i++) begin
                        rnd = (i == bad) ? 8'($urandom_range(0, 255)) : s[i];
                        send_char(rnd);
                    end
                    send_ws();
                end else begin
                    cut = $urandom_range(1, 10);
                    for (int i = 0; i < cut; i++) begin
                        rnd = 8'($urandom_range(0, 255));
                        send_char(rnd);
                    end
                    send_ws();
                end
            end
        end
    endtask

    // Hold the sink long enough for the queue to fill and the input to stall,
    // then pause the source until every report is back
    task automatic test_backpressure();
        wait_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req = 300;
        for (int i = 0; i < 40; i++) begin
            if (i % 4 == 0) send_token({"$", with_sum(rmc_body(), SUM_UPPER)});
            else send_token("$");
        end
        wait_drained();
        for (int i = 0; i < 6; i++) send_token({"$", with_sum("GPRMC,010101,A", SUM_UPPER)});
    endtask

    // A token opening with the stop character reports once; nothing follows
    task automatic test_stop_token();
        wait_drained();
        shield_stop = 1'b0;
        send_token("$xE");                                // stop character mid-token is data
        send_token("ELSE");
        send_token({"$", with_sum("GPRMC,123456,A", SUM_UPPER)});
        send_token("E");
    endtask

    initial begin
        reset_parser();
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_whitespace_only();
        test_valid_sentences();
        test_checksum_cases();
        test_field_cases();
        test_zone_extremes();
        test_random_traffic();
        test_backpressure();
        test_stop_token();

        wait_drained();
        if (errors == 0) begin
            $display("** nmea_rmc_time_extractor: PASSED **");
        end else begin
            $display("** nmea_rmc_time_extractor: FAILED **");
        end
        $finish;
    end

endmodule
